[rtl/core/e0k5_pkg.sv]
// Shared types, reset constants and the generator step function for the
// five-LFSR E0 keystream block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package e0k5_pkg;

   // Register widths of the five shift registers and the combiner carry.
   localparam int unsigned LFSR1_W = 25;
   localparam int unsigned LFSR2_W = 31;
   localparam int unsigned LFSR3_W = 33;
   localparam int unsigned LFSR4_W = 39;
   localparam int unsigned LFSR5_W = 39;
   localparam int unsigned CARRY_W = 2;
   localparam int unsigned BYTE_W  = 8;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 39;

   // Seed values after reset.
   localparam logic [LFSR1_W-1:0] SEED1_RST = 25'h1FF_FFFE;
   localparam logic [LFSR2_W-1:0] SEED2_RST = 31'h7FFF_FFFE;
   localparam logic [LFSR3_W-1:0] SEED3_RST = 33'h1_FFFF_FFFE;
   localparam logic [LFSR4_W-1:0] SEED4_RST = 39'h2A_AAAA_AAAA;
   localparam logic [LFSR5_W-1:0] SEED5_RST = 39'h7F_FFFF_FFFF;
   localparam logic [CARRY_W-1:0] CARRY_RST = 2'd2;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED1 = 3'd0,
      CSR_SEED2 = 3'd1,
      CSR_SEED3 = 3'd2,
      CSR_SEED4 = 3'd3,
      CSR_SEED5 = 3'd4,
      CSR_CARRY = 3'd5
   } csr_index_type;

   // Complete generator state: five LFSRs plus current and previous carry.
   typedef struct packed {
      logic [LFSR1_W-1:0] r1;
      logic [LFSR2_W-1:0] r2;
      logic [LFSR3_W-1:0] r3;
      logic [LFSR4_W-1:0] r4;
      logic [LFSR5_W-1:0] r5;
      logic [CARRY_W-1:0] c_now;
      logic [CARRY_W-1:0] c_prev;
   } gen_state_type;

   // Keystream bit of the current state: XOR of the five LFSR outputs and carry bit 0.
   function automatic logic key_bit(input gen_state_type st);
      key_bit = st.r1[LFSR1_W-1] ^ st.r2[LFSR2_W-1] ^ st.r3[LFSR3_W-1]
              ^ st.r4[LFSR4_W-1] ^ st.r5[LFSR5_W-1] ^ st.c_now[0];
   endfunction

   // One step of the generator: summation combiner update and LFSR shifts.
   function automatic gen_state_type step(input gen_state_type st);
      gen_state_type      nx;
      logic [2:0]         sum;
      logic [CARRY_W-1:0] s;
      logic [CARRY_W-1:0] t2;
      logic               fb1, fb2, fb3, fb4, fb5;
      sum = 3'(st.r1[LFSR1_W-1]) + 3'(st.r2[LFSR2_W-1]) + 3'(st.r3[LFSR3_W-1])
          + 3'(st.r4[LFSR4_W-1]) + 3'(st.c_now);
      s   = sum[2:1];
      t2  = {st.c_prev[0], st.c_prev[1] ^ st.c_prev[0]};
      fb1 = st.r1[24] ^ st.r1[19] ^ st.r1[11] ^ st.r1[7];
      fb2 = st.r2[30] ^ st.r2[23] ^ st.r2[15] ^ st.r2[11];
      fb3 = st.r3[32] ^ st.r3[27] ^ st.r3[23] ^ st.r3[3];
      fb4 = st.r4[38] ^ st.r4[35] ^ st.r4[27] ^ st.r4[3];
      fb5 = st.r5[24] ^ st.r5[14] ^ st.r5[9]  ^ st.r5[4];
      nx.c_prev = st.c_now;
      nx.c_now  = s ^ st.c_now ^ t2;
      nx.r1     = {st.r1[LFSR1_W-2:0], fb1};
      nx.r2     = {st.r2[LFSR2_W-2:0], fb2};
      nx.r3     = {st.r3[LFSR3_W-2:0], fb3};
      nx.r4     = {st.r4[LFSR4_W-2:0], fb4};
      nx.r5     = {st.r5[LFSR5_W-2:0], fb5};
      step      = nx;
   endfunction

endpackage

`default_nettype wire

[rtl/core/e0_keystream_five_lfsr.sv]
// Top level of the five-LFSR E0 keystream cipher: seed registers, generator
// state, eight unrolled generator steps and a two-entry output buffer. Uses e0k5_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block encrypts or decrypts one byte per clock cycle while req_stall is low.
// Each accepted request advances the generator by eight steps, unrolled as eight
// copies of the step logic between the state register and the result register. The
// result appears on rsp_* in the cycle after acceptance when the output register is
// free or is emptied in that cycle; otherwise it waits in the skid entry until the
// output register is taken. An output register and a skid entry let the block
// take requests while a result waits. req_stall rises only when both hold
// results. A request with req_restart set reloads the LFSRs and carries from
// the seed registers before its byte. Seed writes take effect at the next
// restart; reset restores the reset seeds. Writes to indexes above five are ignored.
module e0_keystream_five_lfsr (
   input  wire                                clock,
   input  wire                                reset,
   // Request channel
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [e0k5_pkg::BYTE_W-1:0]        req_data_byte,
   input  wire                                req_restart,
   // Result channel
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [e0k5_pkg::BYTE_W-1:0]        rsp_key_byte,
   output logic [e0k5_pkg::BYTE_W-1:0]        rsp_cipher_byte,
   // Configuration write channel
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [e0k5_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [e0k5_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import e0k5_pkg::*;

   // Generator state right after reset, built from the reset seeds.
   localparam gen_state_type STATE_RST = '{
      r1:     SEED1_RST,
      r2:     SEED2_RST,
      r3:     SEED3_RST,
      r4:     SEED4_RST,
      r5:     SEED5_RST,
      c_now:  CARRY_RST,
      c_prev: CARRY_RST
   };

   logic [LFSR1_W-1:0] seed1_ff;
   logic [LFSR2_W-1:0] seed2_ff;
   logic [LFSR3_W-1:0] seed3_ff;
   logic [LFSR4_W-1:0] seed4_ff;
   logic [LFSR5_W-1:0] seed5_ff;
   logic [CARRY_W-1:0] carry_init_ff;

   gen_state_type      state_ff;
   gen_state_type      state_in;
   gen_state_type      seed_state;
   gen_state_type      stage [0:BYTE_W];
   logic [BYTE_W-1:0]  key_in;
   logic [BYTE_W-1:0]  cipher_in;

   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_key_ff;
   logic [BYTE_W-1:0]  out_cipher_ff;
   logic               skid_valid_ff;
   logic [BYTE_W-1:0]  skid_key_ff;
   logic [BYTE_W-1:0]  skid_cipher_ff;

   logic               req_fire;
   logic               rsp_fire;

   // Handshake decode.
   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !skid_valid_ff;
   assign rsp_fire  = out_valid_ff && !rsp_stall;

   // Seed and carry registers written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed1_ff      <= SEED1_RST;
         seed2_ff      <= SEED2_RST;
         seed3_ff      <= SEED3_RST;
         seed4_ff      <= SEED4_RST;
         seed5_ff      <= SEED5_RST;
         carry_init_ff <= CARRY_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEED1: seed1_ff      <= csr_wdata[LFSR1_W-1:0];
            CSR_SEED2: seed2_ff      <= csr_wdata[LFSR2_W-1:0];
            CSR_SEED3: seed3_ff      <= csr_wdata[LFSR3_W-1:0];
            CSR_SEED4: seed4_ff      <= csr_wdata[LFSR4_W-1:0];
            CSR_SEED5: seed5_ff      <= csr_wdata[LFSR5_W-1:0];
            CSR_CARRY: carry_init_ff <= csr_wdata[CARRY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Generator state as loaded from the seeds.
   always_comb begin
      seed_state.r1     = seed1_ff;
      seed_state.r2     = seed2_ff;
      seed_state.r3     = seed3_ff;
      seed_state.r4     = seed4_ff;
      seed_state.r5     = seed5_ff;
      seed_state.c_now  = carry_init_ff;
      seed_state.c_prev = carry_init_ff;
   end

   // Eight generator steps per byte; the first keystream bit lands in the MSB.
   always_comb begin
      stage[0] = req_restart ? seed_state : state_ff;
      for (int k = 0; k < BYTE_W; k++) begin
         key_in[BYTE_W-1-k] = key_bit(stage[k]);
         stage[k+1]         = step(stage[k]);
      end
      state_in  = stage[BYTE_W];
      cipher_in = req_data_byte ^ key_in;
   end

   // Generator state advances by one byte per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // Output register and skid entry control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_fire) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (req_fire) begin
            if (out_valid_ff && !rsp_fire) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (rsp_fire) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_key_ff    <= skid_key_ff;
            out_cipher_ff <= skid_cipher_ff;
         end
      end else if (req_fire) begin
         if (out_valid_ff && !rsp_fire) begin
            skid_key_ff    <= key_in;
            skid_cipher_ff <= cipher_in;
         end else begin
            out_key_ff    <= key_in;
            out_cipher_ff <= cipher_in;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_byte    = out_key_ff;
   assign rsp_cipher_byte = out_cipher_ff;

`ifndef NO_ASSERTIONS
   // The skid entry is only ever occupied behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // After an accepted request the output register always holds a result in the next cycle.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request produced no result");

   // A taken result with a waiting skid entry keeps the output occupied.
   a_skid_refills: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && skid_valid_ff) |=> (rsp_valid && !skid_valid_ff))
      else $error("skid entry not moved to output register");
`endif

endmodule

`default_nettype wire
